// ===== design/double_ended_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared concurrent assertion forms used by the queue's own checks.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Operation codes and fixed field widths shared by the queue's files.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int OP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

endpackage

// ===== design/deq_if.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue channels
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------
interface deq_req_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [deq_pkg::OP_W-1:0]     op;
    logic signed [DATA_WIDTH-1:0] push_value;

    modport source (output valid, output op, output push_value, input ready);
    modport sink (input valid, input op, input push_value, output ready);
endinterface

interface deq_rsp_if #(
    parameter int DATA_WIDTH = 32,
    parameter int COUNT_W    = 5
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] pop_value;
    logic                         was_empty;
    logic                         was_full;
    logic [COUNT_W-1:0]           entry_count;

    modport source (
        output valid, output pop_value, output was_empty, output was_full,
        output entry_count, input ready
    );
    modport sink (
        input valid, input pop_value, input was_empty, input was_full,
        input entry_count, output ready
    );
endinterface

// ===== design/deq_store.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue ring store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_store #(
    parameter int   DEPTH      = 16,
    parameter int   DATA_WIDTH = 32,
    localparam int  ADDR_W     = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] ring_reg [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue
// A queue of signed words in a ring store that can be pushed and popped at
// either end, or cleared. Every request gives exactly one result carrying the
// popped word (the most negative word when nothing was popped), a flag for a
// pop on an empty queue, a flag for a refused push on a full store, and the
// number of entries held afterwards. One request is accepted in every cycle
// unless a result waits for a stalled sink, and its result appears in the
// following cycle from the registered read of the ring store; the front
// pointer and the count move at the accepting edge. A result still waiting
// for the sink does not block a request in the cycle the sink takes it.
// ----------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0]      DEPTH_C  = CNT_W'(DEPTH);
    localparam logic [CNT_W:0]        DEPTH_X  = (CNT_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    logic                  accept;
    logic [IDX_W-1:0]      front_reg;
    logic [IDX_W-1:0]      front_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic                  pop_hit_reg;
    logic                  was_empty_reg;
    logic                  was_full_reg;

    logic                  is_empty;
    logic                  is_full;
    logic [CNT_W:0]        back_sum;
    logic [CNT_W:0]        back_wrap;
    logic [IDX_W-1:0]      tail_idx;
    logic [IDX_W-1:0]      last_idx;
    logic [IDX_W-1:0]      prev_front;
    logic [IDX_W-1:0]      succ_front;

    logic                  do_write;
    logic                  do_read;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      rd_addr;
    logic                  empty_flag;
    logic                  full_flag;
    logic [DATA_WIDTH-1:0] rd_data;

    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;

    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == DEPTH_C);
    assign back_sum   = (CNT_W + 1)'(front_reg) + (CNT_W + 1)'(count_reg);
    assign back_wrap  = (back_sum >= DEPTH_X) ? (back_sum - DEPTH_X) : back_sum;
    assign tail_idx   = back_wrap[IDX_W-1:0];
    assign last_idx   = (tail_idx == '0) ? LAST_IDX : (tail_idx - 1'b1);
    assign prev_front = (front_reg == '0) ? LAST_IDX : (front_reg - 1'b1);
    assign succ_front = (front_reg == LAST_IDX) ? '0 : (front_reg + 1'b1);

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        do_write   = 1'b0;
        do_read    = 1'b0;
        wr_addr    = tail_idx;
        rd_addr    = front_reg;
        empty_flag = 1'b0;
        full_flag  = 1'b0;
        unique case (req.op)
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    full_flag = 1'b1;
                end
                else
                begin
                    front_next = prev_front;
                    wr_addr    = prev_front;
                    do_write   = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    full_flag = 1'b1;
                end
                else
                begin
                    wr_addr    = tail_idx;
                    do_write   = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    empty_flag = 1'b1;
                end
                else
                begin
                    rd_addr    = front_reg;
                    do_read    = 1'b1;
                    front_next = succ_front;
                    count_next = count_reg - 1'b1;
                end
            end
            deq_pkg::OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    empty_flag = 1'b1;
                end
                else
                begin
                    rd_addr    = last_idx;
                    do_read    = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            deq_pkg::OP_CLEAR:
            begin
                front_next = '0;
                count_next = '0;
            end
            default:
            begin
                front_next = front_reg;
            end
        endcase
    end

    always_comb
    begin
        priority if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop_hit_reg   <= do_read;
            was_empty_reg <= empty_flag;
            was_full_reg  <= full_flag;
        end
    end

    deq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && do_write),
        .wr_addr (wr_addr),
        .wr_data (req.push_value),
        .rd_en   (accept && do_read),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The count register already holds the count after the request on show,
    // as it only moves when the next request is accepted.
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.pop_value   = pop_hit_reg ? rd_data : DATA_MIN;
    assign rsp.was_empty   = was_empty_reg;
    assign rsp.was_full    = was_full_reg;
    assign rsp.entry_count = count_reg;

    `DEQ_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, rsp_valid_reg, "request without result")
    `DEQ_ASSERT_NOW(a_empty_count, clk, rst_n, rsp_valid_reg && was_empty_reg, count_reg == '0, "empty pop with entries held")
    `DEQ_ASSERT_NOW(a_full_count, clk, rst_n, rsp_valid_reg && was_full_reg, count_reg == DEPTH_C, "refused push below capacity")
    `DEQ_ASSERT_NEXT(a_count_hold, clk, rst_n, !accept, $stable(count_reg) && $stable(front_reg), "pointer moved without request")

endmodule

// ===== tb/sv/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop, clear and unused operation requests into the queue and
// keeps a mirror of the ring store, the front pointer and the count. Each
// result is compared with the outcome the mirror worked out for its request.
// Directed requests cover the empty and full queue, the last-entry pop and
// pointer wrap. Random bursts then fill and drain the queue under several
// patterns of source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;

    localparam int QUEUE_DEPTH = 16;
    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 5;
    localparam int INDEX_W     = $clog2(QUEUE_DEPTH);

    localparam logic [deq_pkg::OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [deq_pkg::OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);

    localparam int TENDENCY_FILL  = 0;
    localparam int TENDENCY_DRAIN = 1;
    localparam int TENDENCY_MIXED = 2;

    typedef struct {
        logic signed [WORD_W-1:0] pop_value;
        logic                     was_empty;
        logic                     was_full;
        logic [COUNT_W-1:0]       entry_count;
    } deque_outcome_t;

    class deque_mirror_t;
        logic signed [WORD_W-1:0] ring [QUEUE_DEPTH];
        logic [INDEX_W-1:0]       head;
        logic [COUNT_W-1:0]       held;
        deque_outcome_t           pending_outcomes [$];
        int                       mismatches;

        function new();
            head       = '0;
            held       = '0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return pending_outcomes.size();
        endfunction

        function void note_request(logic [deq_pkg::OP_W-1:0] code,
                                   logic signed [WORD_W-1:0] value);
            deque_outcome_t     outcome;
            logic [INDEX_W-1:0] slot;
            outcome.pop_value = WORD_MIN;
            outcome.was_empty = 1'b0;
            outcome.was_full  = 1'b0;
            unique case (code)
                deq_pkg::OP_PUSH_FRONT:
                begin
                    if (held == FULL_COUNT)
                    begin
                        outcome.was_full = 1'b1;
                    end
                    else
                    begin
                        head       = head - 1'b1;
                        ring[head] = value;
                        held       = held + 1'b1;
                    end
                end
                deq_pkg::OP_PUSH_BACK:
                begin
                    if (held == FULL_COUNT)
                    begin
                        outcome.was_full = 1'b1;
                    end
                    else
                    begin
                        slot       = head + held[INDEX_W-1:0];
                        ring[slot] = value;
                        held       = held + 1'b1;
                    end
                end
                deq_pkg::OP_POP_FRONT:
                begin
                    if (held == '0)
                    begin
                        outcome.was_empty = 1'b1;
                    end
                    else
                    begin
                        outcome.pop_value = ring[head];
                        head              = head + 1'b1;
                        held              = held - 1'b1;
                    end
                end
                deq_pkg::OP_POP_BACK:
                begin
                    if (held == '0)
                    begin
                        outcome.was_empty = 1'b1;
                    end
                    else
                    begin
                        slot              = head + held[INDEX_W-1:0] - 1'b1;
                        outcome.pop_value = ring[slot];
                        held              = held - 1'b1;
                    end
                end
                deq_pkg::OP_CLEAR:
                begin
                    head = '0;
                    held = '0;
                end
                default:
                begin
                end
            endcase
            outcome.entry_count = held;
            pending_outcomes.push_back(outcome);
        endfunction

        function void check_result(logic signed [WORD_W-1:0] pop_value, logic was_empty,
                                   logic was_full, logic [COUNT_W-1:0] entry_count);
            deque_outcome_t want;
            if (pending_outcomes.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                mismatches++;
                return;
            end
            want = pending_outcomes.pop_front();
            if (pop_value !== want.pop_value)
            begin
                $error("pop_value expected %0d got %0d", want.pop_value, pop_value);
                mismatches++;
            end
            if (was_empty !== want.was_empty)
            begin
                $error("was_empty expected %0b got %0b", want.was_empty, was_empty);
                mismatches++;
            end
            if (was_full !== want.was_full)
            begin
                $error("was_full expected %0b got %0b", want.was_full, was_full);
                mismatches++;
            end
            if (entry_count !== want.entry_count)
            begin
                $error("entry_count expected %0d got %0d", want.entry_count, entry_count);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    int sender_gap_pct     = 0;
    int receiver_stall_pct = 0;
    int receiver_hold      = 0;

    deque_mirror_t mirror = new();

    deq_req_if #(.DATA_WIDTH(WORD_W)) req_ch ();
    deq_rsp_if #(.DATA_WIDTH(WORD_W), .COUNT_W(COUNT_W)) rsp_ch ();

    double_ended_queue #(
        .DEPTH      (QUEUE_DEPTH),
        .DATA_WIDTH (WORD_W)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                mirror.check_result(rsp_ch.pop_value, rsp_ch.was_empty, rsp_ch.was_full,
                                    rsp_ch.entry_count);
            end
            if (req_ch.valid && req_ch.ready)
            begin
                mirror.note_request(req_ch.op, req_ch.push_value);
            end
        end
    end

    // The long hold-off is counted here so that the source keeps offering requests.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (receiver_hold > 0)
            begin
                rsp_ch.ready  <= 1'b0;
                receiver_hold = receiver_hold - 1;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    task automatic send_request(input logic [deq_pkg::OP_W-1:0] code,
                                input logic signed [WORD_W-1:0] value);
        while ($urandom_range(0, 99) < sender_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= code;
        req_ch.push_value <= value;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (mirror.outstanding() != 0);
    endtask

    function automatic logic [deq_pkg::OP_W-1:0] pick_op(input int tendency);
        int roll;
        int push_pct;
        roll = $urandom_range(0, 99);
        if (roll < 1)
        begin
            return deq_pkg::OP_CLEAR;
        end
        if (roll < 3)
        begin
            return deq_pkg::OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
        end
        unique case (tendency)
            TENDENCY_FILL:  push_pct = 80;
            TENDENCY_DRAIN: push_pct = 20;
            default:        push_pct = 50;
        endcase
        if ($urandom_range(0, 99) < push_pct)
        begin
            return $urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
        end
        return $urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_value();
        if ($urandom_range(0, 99) >= 10)
        begin
            return $urandom;
        end
        unique case ($urandom_range(0, 3))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic run_bursts(input int gap_pct, input int stall_pct, input int count);
        int tendency;
        int burst_left;
        sender_gap_pct     = gap_pct;
        receiver_stall_pct = stall_pct;
        burst_left         = 0;
        tendency           = TENDENCY_MIXED;
        repeat (count)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(8, 40);
                tendency   = $urandom_range(TENDENCY_FILL, TENDENCY_MIXED);
            end
            burst_left = burst_left - 1;
            send_request(pick_op(tendency), pick_value());
        end
    endtask

    initial
    begin
        #2000000;
        $display("tb_double_ended_queue failed");
        $finish;
    end

    initial
    begin
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.op         <= deq_pkg::OP_CLEAR;
        req_ch.push_value <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(deq_pkg::OP_POP_FRONT, WORD_MAX);
        send_request(deq_pkg::OP_POP_BACK, WORD_MIN);
        send_request(deq_pkg::OP_CLEAR, '0);
        send_request(OP_RESERVED_FIRST, '1);
        send_request(OP_RESERVED_LAST, WORD_MAX);
        send_request(deq_pkg::OP_PUSH_FRONT, WORD_MIN);
        send_request(deq_pkg::OP_PUSH_BACK, WORD_MAX);
        send_request(deq_pkg::OP_POP_FRONT, '0);
        send_request(deq_pkg::OP_POP_BACK, '0);
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            send_request(i[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK, $urandom);
        end
        send_request(deq_pkg::OP_PUSH_FRONT, '1);
        send_request(deq_pkg::OP_PUSH_BACK, '0);
        send_request(deq_pkg::OP_CLEAR, '0);
        wait_for_drain();

        // The sink is held off while requests keep coming, so the input stalls.
        receiver_hold = 80;
        run_bursts(0, 0, 380);
        wait_for_drain();
        run_bursts(85, 0, 380);
        wait_for_drain();
        run_bursts(0, 85, 380);
        wait_for_drain();
        receiver_hold = 60;
        run_bursts(10, 10, 380);
        wait_for_drain();

        repeat (8) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.outstanding() == 0)
        begin
            $display("tb_double_ended_queue passed");
        end
        else
        begin
            $display("tb_double_ended_queue failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/deq_pkg.sv
design/deq_if.sv
design/deq_store.sv
design/double_ended_queue.sv
tb/sv/tb_double_ended_queue.sv
